FILE: design/scta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_pkg
// Shared types, constants and set-1 scancode tables for the scancode to
// ASCII character FIFO.
// ----------------------------------------------------------------------------
package scta_pkg;

    localparam int FIFO_DEPTH_DEF = 256;

    localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT   = 7'h36;
    localparam logic [7:0] CAPTURE_CHAR = 8'h2D;

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // translator verdict for one scancode
    typedef struct packed {
        logic       cap;
        logic       ch_valid;
        logic [7:0] ch;
    } t_xlate;

    function automatic logic [7:0] f_plain_map(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:  ch = 8'd27;
            7'd2:  ch = "1";
            7'd3:  ch = "2";
            7'd4:  ch = "3";
            7'd5:  ch = "4";
            7'd6:  ch = "5";
            7'd7:  ch = "6";
            7'd8:  ch = "7";
            7'd9:  ch = "8";
            7'd10: ch = "9";
            7'd11: ch = "0";
            7'd12: ch = 8'h2D;
            7'd13: ch = 8'h3D;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = "q";
            7'd17: ch = "w";
            7'd18: ch = "e";
            7'd19: ch = "r";
            7'd20: ch = "t";
            7'd21: ch = "y";
            7'd22: ch = "u";
            7'd23: ch = "i";
            7'd24: ch = "o";
            7'd25: ch = "p";
            7'd26: ch = 8'h5B;
            7'd27: ch = 8'h5D;
            7'd28: ch = 8'h0A;
            7'd30: ch = "a";
            7'd31: ch = "s";
            7'd32: ch = "d";
            7'd33: ch = "f";
            7'd34: ch = "g";
            7'd35: ch = "h";
            7'd36: ch = "j";
            7'd37: ch = "k";
            7'd38: ch = "l";
            7'd39: ch = 8'h3B;
            7'd40: ch = 8'h27;
            7'd41: ch = 8'h60;
            7'd43: ch = 8'h5C;
            7'd44: ch = "z";
            7'd45: ch = "x";
            7'd46: ch = "c";
            7'd47: ch = "v";
            7'd48: ch = "b";
            7'd49: ch = "n";
            7'd50: ch = "m";
            7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;
            7'd53: ch = 8'h2F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd72: ch = 8'd38;
            7'd74: ch = 8'h2D;
            7'd75: ch = 8'd37;
            7'd77: ch = 8'd39;
            7'd78: ch = 8'h2B;
            7'd80: ch = 8'd40;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] f_shift_map(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:  ch = 8'd27;
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h40;
            7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h24;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5E;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2A;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5F;
            7'd13: ch = 8'h2B;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = "Q";
            7'd17: ch = "W";
            7'd18: ch = "E";
            7'd19: ch = "R";
            7'd20: ch = "T";
            7'd21: ch = "Y";
            7'd22: ch = "U";
            7'd23: ch = "I";
            7'd24: ch = "O";
            7'd25: ch = "P";
            7'd26: ch = 8'h7B;
            7'd27: ch = 8'h7D;
            7'd28: ch = 8'h0A;
            7'd30: ch = "A";
            7'd31: ch = "S";
            7'd32: ch = "D";
            7'd33: ch = "F";
            7'd34: ch = "G";
            7'd35: ch = "H";
            7'd36: ch = "J";
            7'd37: ch = "K";
            7'd38: ch = "L";
            7'd39: ch = 8'h3A;
            7'd40: ch = 8'h22;
            7'd41: ch = 8'h7E;
            7'd43: ch = 8'h7C;
            7'd44: ch = "Z";
            7'd45: ch = "X";
            7'd46: ch = "C";
            7'd47: ch = "V";
            7'd48: ch = "B";
            7'd49: ch = "N";
            7'd50: ch = "M";
            7'd51: ch = 8'h3C;
            7'd52: ch = 8'h3E;
            7'd53: ch = 8'h3F;
            7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            7'd74: ch = 8'h2D;
            7'd78: ch = 8'h2B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: design/scancode_to_ascii_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core
// Set-1 scancode translator feeding a character FIFO, with pop and clear.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. A scancode, a clear or an unused op has
// its result registered at the accepting edge; the next one can be taken in
// the following cycle once that result is taken. A pop that finds a character
// passes in S_READ through the memory's read data register, then the result
// register; a pop on an empty buffer answers at the accepting edge. The
// result register frees the input side as soon as the previous result is
// taken. Characters live in a FIFO_DEPTH x 8 memory with no reset; read and
// write pointers and a fill count are cleared by reset and by the clear op.
module scancode_to_ascii_fifo_core #(
    parameter int FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF,
    parameter int CW         = $clog2(FIFO_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_scancode,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_pop_valid,
    output logic [7:0]    o_pop_char,
    output logic          o_capture_request,
    output logic          o_char_stored,
    output logic [CW-1:0] o_fill_level
);
    import scta_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_state        r_state, n_state;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic          r_pop_valid, n_pop_valid;
    logic [7:0]    r_pop_char, n_pop_char;
    logic          r_cap, n_cap;
    logic          r_stored, n_stored;
    logic [CW-1:0] r_fill, n_fill;

    logic          w_accept;
    logic          w_out_free;
    t_op           w_op;
    t_xlate        w_xlate;
    logic          w_we;
    logic          w_re;
    logic [7:0]    w_rdata;

    assign w_op       = t_op'(i_op);
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;

    scta_xlate u_xlate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept && (w_op == OP_SCAN)),
        .i_scancode (i_scancode),
        .o_xlate    (w_xlate)
    );

    scta_mem #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_xlate.ch),
        .i_re    (w_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_pop_valid = r_pop_valid;
        n_pop_char  = r_pop_char;
        n_cap       = r_cap;
        n_stored    = r_stored;
        n_fill      = r_fill;
        w_we        = 1'b0;
        w_re        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_pop_valid = 1'b0;
                    n_pop_char  = 8'h00;
                    n_cap       = 1'b0;
                    n_stored    = 1'b0;
                    case (w_op)
                        OP_SCAN: begin
                            n_cap = w_xlate.cap;
                            // full buffer drops the character quietly
                            if (w_xlate.ch_valid && (r_count < CW'(FIFO_DEPTH))) begin
                                w_we     = 1'b1;
                                n_stored = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_wr_ptr = (r_wr_ptr == AW'(FIFO_DEPTH - 1)) ?
                                           '0 : r_wr_ptr + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                // result is loaded in the next cycle, after the memory read
                                w_re        = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                                n_count     = r_count - 1'b1;
                                n_rd_ptr    = (r_rd_ptr == AW'(FIFO_DEPTH - 1)) ?
                                              '0 : r_rd_ptr + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_fill = n_count;
                end
            end
            S_READ: begin
                // result register is known empty here
                n_out_valid = 1'b1;
                n_pop_valid = 1'b1;
                n_pop_char  = w_rdata;
                n_cap       = 1'b0;
                n_stored    = 1'b0;
                n_fill      = r_count;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_valid <= n_pop_valid;
        r_pop_char  <= n_pop_char;
        r_cap       <= n_cap;
        r_stored    <= n_stored;
        r_fill      <= n_fill;
    end

    assign o_valid           = r_out_valid;
    assign o_pop_valid       = r_pop_valid;
    assign o_pop_char        = r_pop_char;
    assign o_capture_request = r_cap;
    assign o_char_stored     = r_stored;
    assign o_fill_level      = r_fill;

endmodule

FILE: design/scta_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_xlate
// Shift tracking and set-1 scancode to ASCII lookup.
// ----------------------------------------------------------------------------
module scta_xlate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_scancode,
    output scta_pkg::t_xlate     o_xlate
);
    import scta_pkg::*;

    logic       r_shift;
    logic       n_shift;
    logic       w_make;
    logic       w_is_shift;
    logic [6:0] w_key;
    logic [7:0] w_ch;

    always_comb begin
        w_make     = ~i_scancode[7];
        w_key      = i_scancode[6:0];
        w_is_shift = (w_key == KEY_LSHIFT) || (w_key == KEY_RSHIFT);
        w_ch       = r_shift ? f_shift_map(w_key) : f_plain_map(w_key);

        o_xlate.ch       = w_ch;
        o_xlate.cap      = w_make && !w_is_shift && (w_ch == CAPTURE_CHAR);
        o_xlate.ch_valid = w_make && !w_is_shift && (w_ch != 8'h00) &&
                           (w_ch != CAPTURE_CHAR);

        // make of a shift sets, break of a shift clears
        n_shift = r_shift;
        if (i_en && w_is_shift) begin
            n_shift = w_make;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
        end else begin
            r_shift <= n_shift;
        end
    end

endmodule

FILE: design/scta_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_mem
// Character store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scta_mem #(
    parameter int FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF,
    parameter int AW         = $clog2(FIFO_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/scta_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scta_chk
// Port-level checks for the scancode to ASCII character FIFO.
// ----------------------------------------------------------------------------
module scta_chk #(
    parameter int FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF,
    parameter int CW         = $clog2(FIFO_DEPTH + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic [1:0]    i_op,
    input logic          o_valid,
    input logic          o_pop_valid,
    input logic [7:0]    o_pop_char,
    input logic          o_capture_request,
    input logic          o_char_stored,
    input logic [CW-1:0] o_fill_level
);
    import scta_pkg::*;

    // a clear transaction answers next cycle with an empty buffer
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == OP_CLEAR)) |=> (o_valid && (o_fill_level == '0)))
        else $error("clear did not empty the buffer");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill_level <= CW'(FIFO_DEPTH)))
        else $error("fill level beyond depth");

    // a pop result carries no scancode flags, and an empty pop gives no char
    a_pop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pop_valid) |-> (!o_capture_request && !o_char_stored))
        else $error("pop result with scancode flags");

    a_no_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pop_valid) |-> (o_pop_char == 8'h00))
        else $error("character without pop");

    a_stored_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_stored) |-> (o_fill_level != '0) && !o_capture_request)
        else $error("stored character with empty buffer");

endmodule

bind scancode_to_ascii_fifo_core scta_chk #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .CW         (CW)
) u_scta_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_op              (i_op),
    .o_valid           (o_valid),
    .o_pop_valid       (o_pop_valid),
    .o_pop_char        (o_pop_char),
    .o_capture_request (o_capture_request),
    .o_char_stored     (o_char_stored),
    .o_fill_level      (o_fill_level)
);

FILE: tb/tb_scancode_to_ascii_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo_core
// Drives scancode, pop, clear and unused-op transactions into the translator
// and checks every reply against a mirror of the shift flag, the character
// FIFO and its fill level. It starts with directed key cases, then runs
// random typing, pop, clear, noise and buffer-fill bursts, with random
// stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo_core;
    import scta_pkg::*;

    localparam int DEPTH       = FIFO_DEPTH_DEF;
    localparam int ITEM_TARGET = 1850;
    localparam logic [7:0] BREAK_FLAG = 8'h80;

    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_char;
        logic       capture;
        logic       stored;
        logic [8:0] fill;
    } t_reply;

    class kbd_buffer_mirror;
        bit         shift_down;
        bit [7:0]   char_mem [DEPTH];
        bit [7:0]   rd_ptr;
        bit [8:0]   held_count;
        t_reply     replies_due[$];
        int         fail_count;

        bit [7:0] plain_tbl [98] = '{
            8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
            8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
            8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
            8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
            8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
            8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h26, 8'h00, 8'h2D, 8'h25, 8'h00, 8'h27, 8'h2B, 8'h00,
            8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
        };

        bit [7:0] shift_tbl [90] = '{
            8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
            8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
            8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
            8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
            8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
            8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
        };

        function new();
            shift_down = 1'b0;
            rd_ptr     = '0;
            held_count = '0;
            fail_count = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        function void note_transaction(t_op op, bit [7:0] code);
            t_reply   r;
            bit [7:0] ch;
            bit [7:0] wr_slot;
            r = '0;
            case (op)
                OP_SCAN: begin
                    if (!code[7]) begin
                        if (code[6:0] == KEY_LSHIFT || code[6:0] == KEY_RSHIFT) begin
                            shift_down = 1'b1;
                        end else begin
                            if (shift_down)
                                ch = (code < 90) ? shift_tbl[code] : 8'h00;
                            else
                                ch = (code < 98) ? plain_tbl[code] : 8'h00;
                            if (ch == CAPTURE_CHAR) begin
                                r.capture = 1'b1;
                            end else if (ch != 8'h00 && held_count < DEPTH) begin
                                wr_slot = rd_ptr + held_count[7:0];
                                char_mem[wr_slot] = ch;
                                held_count++;
                                r.stored = 1'b1;
                            end
                        end
                    end else if (code[6:0] == KEY_LSHIFT || code[6:0] == KEY_RSHIFT) begin
                        shift_down = 1'b0;
                    end
                end
                OP_POP: begin
                    if (held_count != 0) begin
                        r.pop_valid = 1'b1;
                        r.pop_char  = char_mem[rd_ptr];
                        held_count--;
                        rd_ptr++;
                    end
                end
                OP_CLEAR: begin
                    // shift state survives a clear
                    rd_ptr     = '0;
                    held_count = '0;
                end
                default: ;
            endcase
            r.fill = held_count;
            replies_due.push_back(r);
        endfunction

        task check_reply(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                report_mismatch("reply with no transaction outstanding");
            end else begin
                want = replies_due.pop_front();
                if (got.pop_valid !== want.pop_valid)
                    report_mismatch($sformatf("pop_valid got %0d want %0d",
                                              got.pop_valid, want.pop_valid));
                if (got.pop_char !== want.pop_char)
                    report_mismatch($sformatf("pop_char got %h want %h",
                                              got.pop_char, want.pop_char));
                if (got.capture !== want.capture)
                    report_mismatch($sformatf("capture_request got %0d want %0d",
                                              got.capture, want.capture));
                if (got.stored !== want.stored)
                    report_mismatch($sformatf("char_stored got %0d want %0d",
                                              got.stored, want.stored));
                if (got.fill !== want.fill)
                    report_mismatch($sformatf("fill_level got %0d want %0d",
                                              got.fill, want.fill));
            end
        endtask
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [1:0] i_op       = OP_SCAN;
    logic [7:0] i_scancode = 8'h00;
    logic       i_ready    = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_pop_valid;
    logic [7:0] o_pop_char;
    logic       o_capture_request;
    logic       o_char_stored;
    logic [8:0] o_fill_level;

    kbd_buffer_mirror mirror = new();
    bit idle_on    = 1'b1;
    int items_sent = 0;
    int stall_left = 0;
    int fills_done = 0;
    int pick;

    scancode_to_ascii_fifo_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_scancode       (i_scancode),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pop_valid      (o_pop_valid),
        .o_pop_char       (o_pop_char),
        .o_capture_request(o_capture_request),
        .o_char_stored    (o_char_stored),
        .o_fill_level     (o_fill_level)
    );

    always #1 i_clk = ~i_clk;

    // reply side back-pressure in short bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            mirror.check_reply({o_pop_valid, o_pop_char, o_capture_request,
                                o_char_stored, o_fill_level});
    end

    task automatic push_item(t_op op, bit [7:0] code);
        if (items_sent >= ITEM_TARGET - 300)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_scancode <= code;
        do @(posedge i_clk); while (!o_ready);
        mirror.note_transaction(op, code);
        items_sent++;
    endtask

    task automatic type_key(bit [6:0] key, bit shifted);
        bit [6:0] shift_key;
        shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
        if (shifted)
            push_item(OP_SCAN, {1'b0, shift_key});
        push_item(OP_SCAN, {1'b0, key});
        if ($urandom_range(0, 1))
            push_item(OP_SCAN, BREAK_FLAG | key);
        if (shifted)
            push_item(OP_SCAN, BREAK_FLAG | shift_key);
    endtask

    task automatic pop_burst(int n);
        repeat (n) push_item(OP_POP, 8'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty buffer, table ends, capture keys, arrows, shift
        push_item(OP_POP, 8'h00);
        push_item(OP_NONE, 8'hFF);
        push_item(OP_SCAN, 8'h00);
        push_item(OP_SCAN, 8'h7F);
        push_item(OP_SCAN, 8'h62);
        push_item(OP_SCAN, 8'h61);
        push_item(OP_SCAN, 8'h1E);
        push_item(OP_SCAN, 8'h0C);
        push_item(OP_SCAN, 8'h4A);
        push_item(OP_SCAN, 8'h48);
        push_item(OP_SCAN, 8'h4B);
        push_item(OP_SCAN, 8'h4D);
        push_item(OP_SCAN, 8'h50);
        push_item(OP_SCAN, {1'b0, KEY_LSHIFT});
        push_item(OP_SCAN, 8'h02);
        push_item(OP_SCAN, 8'h48);
        push_item(OP_SCAN, 8'h0C);
        push_item(OP_SCAN, 8'h4A);
        push_item(OP_SCAN, 8'h59);
        push_item(OP_SCAN, 8'h5A);
        push_item(OP_SCAN, 8'h9E);
        push_item(OP_SCAN, BREAK_FLAG | KEY_LSHIFT);
        push_item(OP_SCAN, {1'b0, KEY_RSHIFT});
        push_item(OP_SCAN, BREAK_FLAG | KEY_RSHIFT);
        pop_burst(2);
        push_item(OP_CLEAR, 8'h00);
        pop_burst(1);

        while (items_sent < ITEM_TARGET) begin
            // no idling once the run is in its last part
            idle_on = (items_sent < ITEM_TARGET - 300) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (fills_done == 0 || (pick == 0 && fills_done < 3)) begin
                // type past a full buffer so characters get dropped
                push_item(OP_SCAN, BREAK_FLAG | KEY_LSHIFT);
                repeat (270 + $urandom_range(0, 20))
                    push_item(OP_SCAN, 8'($urandom_range(16, 25)));
                pop_burst($urandom_range(100, 280));
                fills_done++;
            end else if (pick < 10) begin
                repeat ($urandom_range(1, 40)) begin
                    if ($urandom_range(0, 7) == 0)
                        type_key(7'($urandom_range(8'h59, 8'h7F)), $urandom_range(0, 1));
                    else
                        type_key(7'($urandom_range(1, 8'h58)), $urandom_range(0, 3) == 0);
                end
            end else if (pick < 15) begin
                pop_burst($urandom_range(1, 30));
            end else if (pick == 15) begin
                push_item(OP_CLEAR, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 10))
                    push_item(t_op'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (mirror.replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mirror.fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
design/scta_pkg.sv
design/scta_xlate.sv
design/scta_mem.sv
design/scancode_to_ascii_fifo_core.sv
design/scta_chk.sv
tb/tb_scancode_to_ascii_fifo_core.sv
